>>> design/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the free block list allocator
// Field widths, command and status codes, and the controller states.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned BLK_W  = 10;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned VOL_W  = 11;

  localparam logic [VOL_W-1:0] VOL_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FORMAT  = 2'd0,
    FUNC_ALLOC   = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_ZERO_BLK  = 2'd2,
    STAT_OUT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FMT,
    ST_EXEC
  } state_t;

endpackage

>>> design/fba_ifs.sv
// ----------------------------------------------------------------------------
// fba_ifs: command and response channels of the allocator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface fba_cmd_if import fba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FUNC_W-1:0] func;
  logic [BLK_W-1:0]  block_in;

  modport source (output valid, output func, output block_in, input ready);
  modport sink   (input valid, input func, input block_in, output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  block_out;
  logic [CNT_W-1:0]  free_count;
  logic [STAT_W-1:0] status;

  modport source (output valid, output block_out, output free_count, output status,
                  input ready);
  modport sink   (input valid, input block_out, input free_count, input status,
                  output ready);
endinterface

>>> design/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/free_block_list_allocator.sv
// ----------------------------------------------------------------------------
// free_block_list_allocator: LIFO linked free list of volume blocks
// The free list links live in one RAM; head and free count in registers.
//
//   channel   | direction | fields
//   in_cmd    | in        | func, block_in
//   out_rsp   | out       | block_out, free_count, status
//   cfg       | in        | cfg_we, cfg_wdata (volume_blocks)
//
// Allocate, release and the unused command are accepted, then committed.
// An allocate reads the link of the head block in the accept cycle.
// Format writes one link per cycle.
// Reset clears head and free count; the link RAM is not cleared.
// A held response stalls the commit cycle, not the acceptance of a command.
// ----------------------------------------------------------------------------
module free_block_list_allocator
  import fba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [VOL_W-1:0] cfg_wdata,
  fba_cmd_if.sink          in_cmd,
  fba_rsp_if.source        out_rsp
);

  localparam int unsigned LINK_W = $clog2(MAX_BLOCKS);
  localparam int unsigned NW     = ($clog2(MAX_BLOCKS + 1) > VOL_W) ?
                                   $clog2(MAX_BLOCKS + 1) : VOL_W;

  state_t            state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [NW-1:0]     fmt_idx_r, fmt_idx_nxt;
  logic [VOL_W-1:0]  vol_r;

  logic              out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]  out_blk_r, out_blk_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [NW-1:0]     vol_ext;
  logic [NW-1:0]     eff_n;
  logic [NW-1:0]     fmt_idx_inc;
  logic              slot_free;
  logic              cmd_accept;
  logic              commit;

  logic              ram_we;
  logic [LINK_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic              ram_re;
  logic [LINK_W-1:0] ram_rdata;

  fba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  // Effective volume size: zero reads as one, larger values saturate.
  always_comb begin
    vol_ext = NW'(vol_r);
    if (vol_ext == '0) begin
      eff_n = NW'(1);
    end else if (vol_ext > NW'(MAX_BLOCKS)) begin
      eff_n = NW'(MAX_BLOCKS);
    end else begin
      eff_n = vol_ext;
    end
  end

  assign fmt_idx_inc = NW'(fmt_idx_r + 1'b1);
  assign slot_free   = !out_valid_r || out_rsp.ready;
  assign in_cmd.ready = (state_r == ST_IDLE);
  assign cmd_accept  = in_cmd.valid && in_cmd.ready;
  assign commit      = (state_r == ST_EXEC) && slot_free;
  assign ram_re      = cmd_accept && (in_cmd.func == FUNC_ALLOC) && (head_r != '0);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    blk_nxt       = blk_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    fmt_idx_nxt   = fmt_idx_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_blk_nxt   = out_blk_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = LINK_W'(fmt_idx_r);
    ram_wdata     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_accept) begin
          func_nxt    = in_cmd.func;
          blk_nxt     = in_cmd.block_in;
          fmt_idx_nxt = NW'(1);
          state_nxt   = (in_cmd.func == FUNC_FORMAT) ? ST_FMT : ST_EXEC;
        end
      end
      ST_FMT: begin
        // Chain blocks 1..N-1 in ascending order, last link is none.
        if (fmt_idx_r < eff_n) begin
          ram_we      = 1'b1;
          ram_wdata   = (fmt_idx_inc < eff_n) ? LINK_W'(fmt_idx_inc) : '0;
          fmt_idx_nxt = fmt_idx_inc;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = '0;
          out_stat_nxt  = STAT_OK;
          state_nxt     = ST_IDLE;
          case (func_r)
            FUNC_FORMAT: begin
              head_nxt = (eff_n > NW'(1)) ? LINK_W'(1) : '0;
              free_nxt = ((eff_n - NW'(1)) >= NW'(COUNT_MAX)) ? COUNT_MAX
                                                               : CNT_W'(eff_n - NW'(1));
            end
            FUNC_ALLOC: begin
              if (head_r == '0) begin
                out_stat_nxt = STAT_EMPTY;
              end else begin
                out_blk_nxt = BLK_W'(head_r);
                head_nxt    = ram_rdata;
                if (free_r != '0) begin
                  free_nxt = free_r - 1'b1;
                end
              end
            end
            FUNC_RELEASE: begin
              if (blk_r == '0) begin
                out_stat_nxt = STAT_ZERO_BLK;
              end else if (NW'(blk_r) >= eff_n) begin
                out_stat_nxt = STAT_OUT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = LINK_W'(blk_r);
                ram_wdata = head_r;
                head_nxt  = LINK_W'(blk_r);
                if (free_r != COUNT_MAX) begin
                  free_nxt = free_r + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          out_cnt_nxt = free_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      free_r      <= '0;
      vol_r       <= VOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vol_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    blk_r      <= blk_nxt;
    fmt_idx_r  <= fmt_idx_nxt;
    out_blk_r  <= out_blk_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.block_out  = out_blk_r;
  assign out_rsp.free_count = out_cnt_r;
  assign out_rsp.status     = out_stat_r;

`ifndef SYNTHESIS
  // A new response only appears after a commit cycle.
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("response raised without a commit");

  // The format walk never runs past the end of the volume.
  a_fmt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FMT) |-> (fmt_idx_r <= eff_n))
    else $error("format index beyond volume");

  // A successful allocate hands out the block that was the list head.
  a_alloc_head: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (func_r == FUNC_ALLOC) && (head_r != '0))
      |=> (out_rsp.block_out == BLK_W'($past(head_r))))
    else $error("allocated block differs from list head");

  // An empty-list answer never carries a block.
  a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == STAT_EMPTY)) |-> (out_blk_r == '0))
    else $error("empty status with nonzero block");
`endif

endmodule
